>>> rtl/olid_pkg.sv
// ----------------------------------------------------------------------------
// olid_pkg
// Shared types and constants for the ordered list insert/delete block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package olid_pkg;

  localparam int CAPACITY = 32;
  localparam int DATA_W   = 32;
  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [CNT_W-1:0]  CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0]  CNT_CAP  = CNT_W'(CAPACITY);
  localparam logic [ADDR_W-1:0] ADDR_ONE = ADDR_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD_FRONT = 3'd0,
    MODE_ADD_KEY   = 3'd1,
    MODE_ADD_REAR  = 3'd2,
    MODE_REM_FRONT = 3'd3,
    MODE_REM_KEY   = 3'd4,
    MODE_REM_REAR  = 3'd5
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_NOKEY = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHUP,
    S_RDREM,
    S_RDCAP,
    S_SHDN,
    S_DONE
  } state_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_SET_ST,
    DP_POS_FRONT,
    DP_POS_REAR,
    DP_POS_LAST,
    DP_SCAN,
    DP_SCAN_INS,
    DP_SCAN_REM,
    DP_SHUP,
    DP_PUT,
    DP_RD_POS,
    DP_CAP,
    DP_SHDN,
    DP_SHRINK
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e st;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              empty;
    logic              scan_done;
    logic              scan_hit;
    logic              up_done;
    logic              dn_done;
  } stat_t;

endpackage

>>> rtl/ordered_list_insert_delete.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// Ordered list of up to 32 signed 32-bit values with six insert/remove modes.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; the block then stays
// busy until it raises done_o for exactly one cycle with status, removed value
// and the new entry count. The receiver cannot stall, so the result must be
// captured in that cycle. Requests are handled one at a time. A request
// refused as full or empty, or with an unused mode, goes straight from decode
// to the result. Add rear and remove rear shift no entries; add front and
// remove front shift every entry; keyed modes scan first (one entry per cycle,
// stopping at the first match) and then shift only the entries behind the
// match, so scan and shift together walk the list once. Scans and shifts
// move one entry per cycle, set by the single write and single read port of
// the entry RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ordered_list_insert_delete import olid_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic        [MODE_W-1:0]   mode_i,
  input  logic signed [DATA_W-1:0]   key_i,
  input  logic signed [DATA_W-1:0]   value_i,
  output logic                       done_o,
  output logic        [STATUS_W-1:0] status_o,
  output logic signed [DATA_W-1:0]   removed_value_o,
  output logic        [COUNT_W-1:0]  entry_count_o
);

  // controller <-> datapath
  cmd_t  cmd;
  stat_t stat;

  olid_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  // entries sit densely from front (address 0) to rear; inserts and removals
  // in the middle shift the tail one entry per cycle
  olid_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .mode_i    (mode_i),
    .key_i     (key_i),
    .value_i   (value_i),
    .status_o  (status_o),
    .removed_o (removed_value_o),
    .count_o   (entry_count_o)
  );

endmodule

>>> rtl/olid_ram.sv
// ----------------------------------------------------------------------------
// olid_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/olid_dp.sv
// ----------------------------------------------------------------------------
// olid_dp
// Datapath: request registers, length, walk counters and the entry RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olid_dp import olid_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output stat_t               stat_o,
  input  logic [MODE_W-1:0]   mode_i,
  input  logic [DATA_W-1:0]   key_i,
  input  logic [DATA_W-1:0]   value_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [DATA_W-1:0]   removed_o,
  output logic [COUNT_W-1:0]  count_o
);

  logic [MODE_W-1:0]   mode_q;
  logic [DATA_W-1:0]   key_q, val_q;
  logic [CNT_W-1:0]    len_q, len_d;
  logic [CNT_W-1:0]    idx_q, idx_d;
  logic [CNT_W-1:0]    pos_q, pos_d;
  logic                vld_q, vld_d;
  logic [ADDR_W-1:0]   rd_addr_q, rd_addr_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [DATA_W-1:0]   removed_q, removed_d;

  logic [CNT_W-1:0]    idx_m1;
  logic                we;
  logic [ADDR_W-1:0]   waddr;
  logic [DATA_W-1:0]   wdata;
  logic [DATA_W-1:0]   rdata;

  assign idx_m1 = idx_q - CNT_ONE;

  always_comb begin
    len_d     = len_q;
    idx_d     = idx_q;
    pos_d     = pos_q;
    vld_d     = 1'b0;
    rd_addr_d = rd_addr_q;
    status_d  = status_q;
    removed_d = removed_q;
    case (cmd_i.op)
      DP_LOAD: begin
        idx_d     = '0;
        status_d  = ST_OK;
        removed_d = '0;
      end
      DP_SET_ST:    status_d = cmd_i.st;
      DP_POS_FRONT: begin
        pos_d = '0;
        idx_d = len_q;
      end
      DP_POS_REAR: begin
        pos_d = len_q;
        idx_d = len_q;
      end
      DP_POS_LAST:  pos_d = len_q - CNT_ONE;
      DP_SCAN, DP_SHDN: begin
        if (idx_q != len_q) begin
          rd_addr_d = idx_q[ADDR_W-1:0];
          idx_d     = idx_q + CNT_ONE;
          vld_d     = 1'b1;
        end
      end
      DP_SCAN_INS: begin
        // next slot after the hit, or the rear on a miss: both equal idx
        pos_d = idx_q;
        idx_d = len_q;
      end
      DP_SCAN_REM:  pos_d = idx_m1;
      DP_SHUP: begin
        if (idx_q != pos_q) begin
          rd_addr_d = idx_m1[ADDR_W-1:0];
          idx_d     = idx_m1;
          vld_d     = 1'b1;
        end
      end
      DP_PUT:       len_d = len_q + CNT_ONE;
      DP_RD_POS:    rd_addr_d = pos_q[ADDR_W-1:0];
      DP_CAP: begin
        removed_d = rdata;
        idx_d     = pos_q + CNT_ONE;
      end
      DP_SHRINK:    len_d = len_q - CNT_ONE;
      default: ;
    endcase
  end

  // RAM read address is the one being issued this cycle
  always_comb begin
    we    = 1'b0;
    waddr = pos_q[ADDR_W-1:0];
    wdata = val_q;
    if (vld_q && cmd_i.op == DP_SHUP) begin
      we    = 1'b1;
      waddr = rd_addr_q + ADDR_ONE;
      wdata = rdata;
    end else if (vld_q && cmd_i.op == DP_SHDN) begin
      we    = 1'b1;
      waddr = rd_addr_q - ADDR_ONE;
      wdata = rdata;
    end else if (cmd_i.op == DP_PUT) begin
      we    = 1'b1;
    end
  end

  olid_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (rd_addr_d),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      vld_q <= 1'b0;
      idx_q <= '0;
      pos_q <= '0;
    end else begin
      len_q <= len_d;
      vld_q <= vld_d;
      idx_q <= idx_d;
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_LOAD) begin
      mode_q <= mode_i;
      key_q  <= key_i;
      val_q  <= value_i;
    end
    rd_addr_q <= rd_addr_d;
    status_q  <= status_d;
    removed_q <= removed_d;
  end

  always_comb begin
    stat_o.mode      = mode_q;
    stat_o.full      = (len_q == CNT_CAP);
    stat_o.empty     = (len_q == '0);
    stat_o.scan_hit  = vld_q && (rdata == key_q);
    stat_o.scan_done = stat_o.scan_hit || (idx_q == len_q);
    stat_o.up_done   = !vld_q && (idx_q == pos_q);
    stat_o.dn_done   = !vld_q && (idx_q == len_q);
  end

  assign status_o  = status_q;
  assign removed_o = removed_q;
  assign count_o   = COUNT_W'(len_q);

endmodule

>>> rtl/olid_ctrl.sv
// ----------------------------------------------------------------------------
// olid_ctrl
// Request sequencer: decode, key scan, shift walks and result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olid_ctrl import olid_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start,
  output logic  busy,
  output logic  done_o,
  output cmd_t  cmd_o,
  input  stat_t stat_i
);

  state_e state_q, state_d;
  logic   is_ins, is_rem;

  assign is_ins = stat_i.mode inside {MODE_ADD_FRONT, MODE_ADD_KEY, MODE_ADD_REAR};
  assign is_rem = stat_i.mode inside {MODE_REM_FRONT, MODE_REM_KEY, MODE_REM_REAR};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (start) state_d = S_DECODE;
      S_DECODE: begin
        if ((is_ins && stat_i.full) || (is_rem && stat_i.empty)) begin
          state_d = S_DONE;
        end else begin
          case (stat_i.mode)
            MODE_ADD_FRONT, MODE_ADD_REAR:  state_d = S_SHUP;
            MODE_ADD_KEY, MODE_REM_KEY:     state_d = S_SCAN;
            MODE_REM_FRONT, MODE_REM_REAR:  state_d = S_RDREM;
            default:                        state_d = S_DONE;
          endcase
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          if (stat_i.mode == MODE_ADD_KEY) state_d = S_SHUP;
          else if (stat_i.scan_hit)        state_d = S_RDREM;
          else                             state_d = S_DONE;
        end
      end
      S_SHUP:   if (stat_i.up_done) state_d = S_DONE;
      S_RDREM:  state_d = S_RDCAP;
      S_RDCAP:  state_d = S_SHDN;
      S_SHDN:   if (stat_i.dn_done) state_d = S_DONE;
      S_DONE:   state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = DP_NOP;
    cmd_o.st = ST_OK;
    case (state_q)
      S_IDLE:   if (start) cmd_o.op = DP_LOAD;
      S_DECODE: begin
        if (is_ins && stat_i.full) begin
          cmd_o.op = DP_SET_ST;
          cmd_o.st = ST_FULL;
        end else if (is_rem && stat_i.empty) begin
          cmd_o.op = DP_SET_ST;
          cmd_o.st = ST_EMPTY;
        end else begin
          case (stat_i.mode)
            MODE_ADD_FRONT, MODE_REM_FRONT: cmd_o.op = DP_POS_FRONT;
            MODE_ADD_REAR:                  cmd_o.op = DP_POS_REAR;
            MODE_REM_REAR:                  cmd_o.op = DP_POS_LAST;
            default:                        cmd_o.op = DP_NOP;
          endcase
        end
      end
      S_SCAN: begin
        if (!stat_i.scan_done) begin
          cmd_o.op = DP_SCAN;
        end else if (stat_i.mode == MODE_ADD_KEY) begin
          cmd_o.op = DP_SCAN_INS;
        end else if (stat_i.scan_hit) begin
          cmd_o.op = DP_SCAN_REM;
        end else begin
          cmd_o.op = DP_SET_ST;
          cmd_o.st = ST_NOKEY;
        end
      end
      S_SHUP:   cmd_o.op = stat_i.up_done ? DP_PUT : DP_SHUP;
      S_RDREM:  cmd_o.op = DP_RD_POS;
      S_RDCAP:  cmd_o.op = DP_CAP;
      S_SHDN:   cmd_o.op = stat_i.dn_done ? DP_SHRINK : DP_SHDN;
      default:  cmd_o.op = DP_NOP;
    endcase
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/olid_checker.sv
// ----------------------------------------------------------------------------
// olid_checker
// Port-level checks for the ordered list block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olid_checker import olid_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic [MODE_W-1:0]   mode_i,
  input logic [DATA_W-1:0]   key_i,
  input logic [DATA_W-1:0]   value_i,
  input logic                done_o,
  input logic [STATUS_W-1:0] status_o,
  input logic [DATA_W-1:0]   removed_value_o,
  input logic [COUNT_W-1:0]  entry_count_o
);

  // an accepted item always holds the block busy next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // one strobe per item, and only while busy
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy ##1 !done_o)
    else $error("result strobe not a single busy cycle");

  // a full rejection leaves the list at capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_FULL |-> entry_count_o == COUNT_W'(CAPACITY))
    else $error("full status with count below capacity");

  // an empty rejection removes nothing
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == ST_EMPTY |-> entry_count_o == '0 && removed_value_o == '0)
    else $error("empty status with entries or removed value");

  // only a successful request can report a nonzero removed value
  a_removed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && removed_value_o != '0 |-> status_o == ST_OK)
    else $error("removed value on a failed request");

endmodule

bind ordered_list_insert_delete olid_checker u_olid_checker (.*);

>>> tb/olid_checker.sv
// ----------------------------------------------------------------------------
// olid_tb_checker
// Scoreboard for the ordered list block: mirrors the list and checks results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olid_tb_checker import olid_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  input  logic                       busy,
  input  logic        [MODE_W-1:0]   mode_i,
  input  logic signed [DATA_W-1:0]   key_i,
  input  logic signed [DATA_W-1:0]   value_i,
  input  logic                       done_o,
  input  logic        [STATUS_W-1:0] status_o,
  input  logic signed [DATA_W-1:0]   removed_value_o,
  input  logic        [COUNT_W-1:0]  entry_count_o,
  output int                         fail_count,
  output int                         pending
);

  typedef struct {
    status_e                   status;
    logic signed [DATA_W-1:0]  removed;
    logic        [COUNT_W-1:0] count;
  } list_result_t;

  logic signed [DATA_W-1:0] shadow_list[$];   // front at index 0
  list_result_t             awaited_results[$];

  // first index holding k, or the list size on a miss
  function automatic int locate_key(logic signed [DATA_W-1:0] k);
    for (int i = 0; i < shadow_list.size(); i++) begin
      if (shadow_list[i] == k) return i;
    end
    return shadow_list.size();
  endfunction

  function automatic list_result_t apply_request(logic [MODE_W-1:0] m,
                                                 logic signed [DATA_W-1:0] k,
                                                 logic signed [DATA_W-1:0] v);
    list_result_t r;
    int           pos;
    logic         is_ins;
    logic         is_rem;
    r.status  = ST_OK;
    r.removed = '0;
    is_ins    = (m <= MODE_ADD_REAR);
    is_rem    = (m >= MODE_REM_FRONT) && (m <= MODE_REM_REAR);
    if (is_ins && shadow_list.size() >= CAPACITY) begin
      r.status = ST_FULL;
    end else if (is_rem && shadow_list.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      case (m)
        MODE_ADD_FRONT: shadow_list.push_front(v);
        MODE_ADD_KEY: begin
          pos = locate_key(k);
          if (pos < shadow_list.size()) shadow_list.insert(pos + 1, v);
          else shadow_list.push_back(v);
        end
        MODE_ADD_REAR:  shadow_list.push_back(v);
        MODE_REM_FRONT: r.removed = shadow_list.pop_front();
        MODE_REM_KEY: begin
          pos = locate_key(k);
          if (pos < shadow_list.size()) begin
            r.removed = shadow_list[pos];
            shadow_list.delete(pos);
          end else begin
            r.status = ST_NOKEY;
          end
        end
        MODE_REM_REAR:  r.removed = shadow_list.pop_back();
        default: ;      // unused modes leave the list alone
      endcase
    end
    r.count = COUNT_W'(shadow_list.size());
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t want;
    int           errs;
    if (!rst_ni) begin
      shadow_list.delete();
      awaited_results.delete();
      fail_count <= 0;
      pending    <= 0;
    end else begin
      errs = 0;
      // retire the finished request before taking a new one
      if (done_o) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request outstanding");
          errs++;
        end else begin
          want = awaited_results.pop_front();
          if (status_o !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status_o);
            errs++;
          end
          if (removed_value_o !== want.removed) begin
            $error("removed_value: expected %0d, actual %0d", want.removed,
                   removed_value_o);
            errs++;
          end
          if (entry_count_o !== want.count) begin
            $error("entry_count: expected %0d, actual %0d", want.count,
                   entry_count_o);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        awaited_results.push_back(apply_request(mode_i, key_i, value_i));
      end
      if (errs != 0) begin
        fail_count <= fail_count + errs;
      end
      pending <= awaited_results.size();
    end
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the ordered list insert/delete block.
// ----------------------------------------------------------------------------
// A directed pass covers the empty list, the unused modes, keyed hits and
// misses and the extreme words. The random pass then runs in bursts that lean
// toward inserts or removals, so the list keeps swinging between empty and
// full. Four words in ten come from a small pool, so keyed requests hit often.
// The sender idles while a draw falls under 13 percent, then 54, then never.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import olid_pkg::*;

  localparam int RAND_ITEMS   = 1000;
  localparam int QUIET_LIMIT  = 2000;  // cycles with no item and no result
  localparam int DRAIN_CYCLES = 80;

  logic                       clk_i;
  logic                       rst_ni          = 1'b0;
  logic                       start           = 1'b0;
  logic        [MODE_W-1:0]   mode_i          = '0;
  logic signed [DATA_W-1:0]   key_i           = '0;
  logic signed [DATA_W-1:0]   value_i         = '0;
  logic                       busy;
  logic                       done_o;
  logic        [STATUS_W-1:0] status_o;
  logic signed [DATA_W-1:0]   removed_value_o;
  logic        [COUNT_W-1:0]  entry_count_o;
  int                         fail_count;
  int                         pending;
  int                         quiet_cycles = 0;

  ordered_list_insert_delete dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .key_i           (key_i),
    .value_i         (value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .entry_count_o   (entry_count_o)
  );

  olid_tb_checker list_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .key_i           (key_i),
    .value_i         (value_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .entry_count_o   (entry_count_o),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: a hung block shows up as a long run of silent cycles.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Four in ten from a small pool (hits for keyed modes), four extremes, two full words.
  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(9))
      0:       return 32'sh7fff_ffff;
      1:       return 32'sh8000_0000;
      2:       return 32'sh0;
      3:       return -32'sd1;
      4, 5:    return $urandom();
      default: return $urandom_range(7);
    endcase
  endfunction

  // Present one item and hold it until taken. busy only moves at the rising
  // edge, so sampling it at the falling edge tells whether the next edge
  // takes the item.
  task automatic issue_request(input logic [MODE_W-1:0] m,
                               input logic signed [DATA_W-1:0] k,
                               input logic signed [DATA_W-1:0] v);
    logic taken;
    start   <= 1'b1;
    mode_i  <= m;
    key_i   <= k;
    value_i <= v;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end
  endtask

  initial begin
    int idle_pct[3];
    int burst_left;
    int ins_pct;
    logic [MODE_W-1:0] m;

    idle_pct = '{13, 54, 0};
    burst_left = 0;
    ins_pct = 50;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // removals on an empty list
    issue_request(MODE_REM_FRONT, 32'sd0, 32'sd0);
    issue_request(MODE_REM_KEY,   32'sd0, 32'sd0);
    issue_request(MODE_REM_REAR,  32'sd0, 32'sd0);
    // unused modes
    issue_request(3'd6, -32'sd1, -32'sd1);
    issue_request(3'd7, 32'sd0, 32'sd0);
    // keyed insert with no match appends
    issue_request(MODE_ADD_KEY,   32'sd9, 32'sd5);
    issue_request(MODE_ADD_FRONT, 32'sd0, 32'sh8000_0000);
    issue_request(MODE_ADD_REAR,  32'sd0, 32'sh7fff_ffff);
    // keyed insert hits the front, then the middle, then misses
    issue_request(MODE_ADD_KEY,   32'sh8000_0000, -32'sd1);
    issue_request(MODE_ADD_KEY,   32'sd5, 32'sd5);
    issue_request(MODE_ADD_KEY,   32'sh1234_5678, 32'sd0);
    issue_request(MODE_ADD_FRONT, -32'sd1, 32'shaaaa_aaaa);
    issue_request(MODE_ADD_REAR,  -32'sd1, 32'sh5555_5555);
    // keyed removal: first of duplicates, miss, extremes
    issue_request(MODE_REM_KEY,   32'sd5, -32'sd1);
    issue_request(MODE_REM_KEY,   32'sh0bad_f00d, 32'sd0);
    issue_request(MODE_REM_KEY,   32'sh7fff_ffff, 32'sd0);
    issue_request(MODE_REM_KEY,   32'shaaaa_aaaa, 32'sd0);
    issue_request(3'd6, 32'sh5555_5555, 32'shaaaa_aaaa);
    issue_request(MODE_REM_FRONT, -32'sd1, -32'sd1);
    issue_request(MODE_REM_REAR,  -32'sd1, -32'sd1);
    issue_request(MODE_REM_KEY,   -32'sd1, 32'sd0);
    issue_request(MODE_REM_FRONT, 32'sd0, 32'sd0);
    issue_request(MODE_REM_REAR,  32'sd0, 32'sd0);

    // --- random, three idle profiles ---
    for (int ph = 0; ph < 3; ph++) begin
      for (int n = 0; n < RAND_ITEMS / 3 + 1; n++) begin
        // sender gap: payload is junk while start is low
        while ($urandom_range(99) < idle_pct[ph]) begin
          start   <= 1'b0;
          mode_i  <= MODE_W'($urandom());
          key_i   <= $urandom();
          value_i <= $urandom();
          @(posedge clk_i);
        end
        // bursts lean toward filling, draining, or neither
        if (burst_left == 0) begin
          burst_left = $urandom_range(10, 60);
          case ($urandom_range(2))
            0:       ins_pct = 85;
            1:       ins_pct = 15;
            default: ins_pct = 50;
          endcase
        end
        burst_left--;
        if ($urandom_range(99) < 3) m = MODE_W'($urandom_range(6, 7));
        else if ($urandom_range(99) < ins_pct) m = MODE_W'($urandom_range(2));
        else m = MODE_W'($urandom_range(5, 3));
        issue_request(m, pick_word(), pick_word());
      end
    end
    start <= 1'b0;

    // let the last result come back, then a little longer for strays
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> ordered_list_insert_delete.f
rtl/olid_pkg.sv
rtl/olid_ram.sv
rtl/olid_dp.sv
rtl/olid_ctrl.sv
rtl/ordered_list_insert_delete.sv
rtl/olid_checker.sv
tb/olid_checker.sv
tb/tb_top.sv
